// File: hdl/rtp_pkt_pkg.sv
// Shared types and constants for the RTP packet parser.
package rtp_pkt_pkg;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_CSRC    = 3'd1,
		KIND_EXT     = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNCATED = 2'd1;
	localparam logic [1:0] ST_OVERRUN   = 2'd2;
	localparam logic [1:0] ST_BAD_PAD   = 2'd3;

	localparam logic [15:0] PROFILE_ONE = 16'hBEDE;
	localparam logic [15:0] PROFILE_TWO = 16'h1000;

	localparam logic [3:0] ID_RESERVED = 4'hF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  version;
		logic [2:0]  flags;
		logic [6:0]  ptype;
		logic [15:0] seq_num;
		logic [31:0] timestamp;
		logic [31:0] source_id;
		logic [7:0]  element_id;
		logic [31:0] data_value;
		logic [7:0]  pad_bytes;
		logic [1:0]  status;
		logic        packet_done;
	} res_t;

endpackage

// File: hdl/rtp_pkt_core.sv
// Byte-serial RTP header parser: packet state and the results of one byte.
module rtp_pkt_core #(
	parameter int POSITION_BITS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output rtp_pkt_pkg::res_t  res0,
	output rtp_pkt_pkg::res_t  res1,
	output logic [1:0]         res_count
);
	import rtp_pkt_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int SW = ((PB > 18) ? PB : 18) + 1;
	localparam logic [PB-1:0] POS_MAX = '1;

	typedef enum logic [3:0] {
		PH_FIXED     = 4'd0,
		PH_CSRC      = 4'd1,
		PH_EXTHDR    = 4'd2,
		PH_ONE_HDR   = 4'd3,
		PH_TWO_ID    = 4'd4,
		PH_TWO_LEN   = 4'd5,
		PH_ELEM_DATA = 4'd6,
		PH_SKIP      = 4'd7,
		PH_OPAQUE    = 4'd8,
		PH_PAYLOAD   = 4'd9
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [PB-1:0] pos_q, npos, end_q, end_n, pcount_q, pcount_n, rel_c, rel_e;
	logic [3:0]  csrc_q, csrc_n;
	logic [2:0]  flags_q, flags_n;
	logic [31:0] acc_q, acc_n, time_q, time_n, src_q, src_n;
	logic [15:0] seq_q, seq_n, prof_q, prof_n;
	logic [7:0]  eid_q, eid_n;
	logic [8:0]  left_q, left_n;
	logic [1:0]  ver_q, ver_n;
	logic [6:0]  pt_q, pt_n;
	logic        ovr_q, ovr_n;
	logic        hdr_check, have_main;
	logic [4:0]  word_idx;
	logic [SW-1:0] ext_sum;
	phase_t      elem_hdr_ph;
	res_t        rm, re;

	always_comb begin
		phase_n   = phase_q;
		csrc_n    = csrc_q;
		flags_n   = flags_q;
		time_n    = time_q;
		src_n     = src_q;
		seq_n     = seq_q;
		prof_n    = prof_q;
		end_n     = end_q;
		eid_n     = eid_q;
		left_n    = left_q;
		ver_n     = ver_q;
		pt_n      = pt_q;
		ovr_n     = ovr_q;
		pcount_n  = pcount_q;
		hdr_check = 1'b0;
		have_main = 1'b0;
		rm        = '0;
		re        = '0;

		acc_n = {acc_q[23:0], data_byte};
		npos  = (pos_q != POS_MAX) ? pos_q + PB'(1) : pos_q;
		rel_c = pos_q - PB'(12);
		rel_e = pos_q - PB'(12) - PB'({csrc_q, 2'b00});
		word_idx = {1'b0, rel_c[5:2]} + 5'd1;
		ext_sum  = SW'(npos) + SW'({acc_n[15:0], 2'b00});
		elem_hdr_ph = (prof_q == PROFILE_ONE) ? PH_ONE_HDR : PH_TWO_ID;

		rm.version   = ver_q;
		rm.flags     = flags_q;
		rm.ptype     = pt_q;
		rm.seq_num   = seq_q;
		rm.timestamp = time_q;
		rm.source_id = src_q;

		case (phase_q)
			PH_FIXED: begin
				if (pos_q == '0) begin
					ver_n   = data_byte[7:6];
					flags_n = {data_byte[5], data_byte[4], flags_q[0]};
					csrc_n  = data_byte[3:0];
				end else if (pos_q == PB'(1)) begin
					flags_n = {flags_q[2:1], data_byte[7]};
					pt_n    = data_byte[6:0];
				end else if (pos_q == PB'(3)) begin
					seq_n = acc_n[15:0];
				end else if (pos_q == PB'(7)) begin
					time_n = acc_n;
				end else if (pos_q >= PB'(11)) begin
					src_n = acc_n;
					rm.source_id = acc_n;
					if (!flags_q[1]) begin
						have_main = 1'b1;
						rm.kind   = KIND_HEADER;
						phase_n   = (csrc_q != 4'd0) ? PH_CSRC : PH_PAYLOAD;
					end else begin
						phase_n = (csrc_q != 4'd0) ? PH_CSRC : PH_EXTHDR;
					end
				end
			end
			PH_CSRC: begin
				if (pos_q[1:0] == 2'b11) begin
					have_main = 1'b1;
					rm = '0;
					rm.kind = KIND_CSRC;
					rm.data_value = acc_n;
					if (word_idx >= {1'b0, csrc_q}) begin
						phase_n = flags_q[1] ? PH_EXTHDR : PH_PAYLOAD;
					end
				end
			end
			PH_EXTHDR: begin
				if (rel_e == PB'(1)) begin
					prof_n = acc_n[15:0];
					have_main = 1'b1;
					rm.kind = KIND_HEADER;
					rm.data_value = {16'd0, acc_n[15:0]};
				end else if (rel_e >= PB'(3)) begin
					end_n = (ext_sum > SW'(POS_MAX)) ? POS_MAX : ext_sum[PB-1:0];
					if (prof_q == PROFILE_ONE || prof_q == PROFILE_TWO) begin
						phase_n = elem_hdr_ph;
					end else begin
						phase_n = PH_OPAQUE;
					end
					hdr_check = 1'b1;
				end
			end
			PH_ONE_HDR: begin
				if (data_byte != 8'd0) begin
					eid_n  = {4'd0, data_byte[7:4]};
					left_n = {5'd0, data_byte[3:0]} + 9'd1;
					phase_n = (data_byte[7:4] == ID_RESERVED) ? PH_SKIP : PH_ELEM_DATA;
				end
				hdr_check = (phase_n != PH_ELEM_DATA);
			end
			PH_TWO_ID: begin
				if (data_byte != 8'd0) begin
					eid_n   = data_byte;
					phase_n = PH_TWO_LEN;
				end else begin
					hdr_check = 1'b1;
				end
			end
			PH_TWO_LEN: begin
				if (pos_q >= end_q) begin
					ovr_n = 1'b1;
				end
				left_n = {1'b0, data_byte};
				if (data_byte == 8'd0) begin
					phase_n   = PH_TWO_ID;
					hdr_check = 1'b1;
				end else begin
					phase_n = PH_ELEM_DATA;
				end
			end
			PH_ELEM_DATA: begin
				if (pos_q >= end_q) begin
					ovr_n = 1'b1;
				end
				have_main = 1'b1;
				rm = '0;
				rm.kind = KIND_EXT;
				rm.element_id = eid_q;
				rm.data_value = {24'd0, data_byte};
				left_n = left_q - 9'd1;
				if (left_n == 9'd0) begin
					phase_n   = elem_hdr_ph;
					hdr_check = 1'b1;
				end
			end
			PH_SKIP: begin
				hdr_check = 1'b1;
			end
			PH_OPAQUE: begin
				have_main = 1'b1;
				rm = '0;
				rm.kind = KIND_EXT;
				rm.data_value = {24'd0, data_byte};
				hdr_check = 1'b1;
			end
			default: begin
				phase_n = PH_PAYLOAD;
				have_main = 1'b1;
				rm = '0;
				rm.kind = KIND_PAYLOAD;
				rm.data_value = {24'd0, data_byte};
				if (pcount_q != POS_MAX) begin
					pcount_n = pcount_q + PB'(1);
				end
			end
		endcase

		if (hdr_check && npos >= end_n) begin
			phase_n = PH_PAYLOAD;
		end

		re.kind = KIND_END;
		re.packet_done = 1'b1;
		if (phase_n != PH_PAYLOAD) begin
			re.status = ST_TRUNCATED;
		end else if (ovr_n) begin
			re.status = ST_OVERRUN;
		end else if (flags_n[2]) begin
			if (pcount_n == '0 || PB'(data_byte) > pcount_n) begin
				re.status = ST_BAD_PAD;
			end else begin
				re.pad_bytes = data_byte;
			end
		end

		res0 = have_main ? rm : re;
		res1 = re;
		res_count = {1'b0, have_main} + {1'b0, last_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIXED;
			pos_q    <= '0;
			csrc_q   <= '0;
			flags_q  <= '0;
			acc_q    <= '0;
			seq_q    <= '0;
			time_q   <= '0;
			src_q    <= '0;
			prof_q   <= '0;
			end_q    <= '0;
			eid_q    <= '0;
			left_q   <= '0;
			pcount_q <= '0;
			ver_q    <= '0;
			pt_q     <= '0;
			ovr_q    <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				phase_q  <= PH_FIXED;
				pos_q    <= '0;
				csrc_q   <= '0;
				flags_q  <= '0;
				acc_q    <= '0;
				seq_q    <= '0;
				time_q   <= '0;
				src_q    <= '0;
				prof_q   <= '0;
				end_q    <= '0;
				eid_q    <= '0;
				left_q   <= '0;
				pcount_q <= '0;
				ver_q    <= '0;
				pt_q     <= '0;
				ovr_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= npos;
				csrc_q   <= csrc_n;
				flags_q  <= flags_n;
				acc_q    <= acc_n;
				seq_q    <= seq_n;
				time_q   <= time_n;
				src_q    <= src_n;
				prof_q   <= prof_n;
				end_q    <= end_n;
				eid_q    <= eid_n;
				left_q   <= left_n;
				pcount_q <= pcount_n;
				ver_q    <= ver_n;
				pt_q     <= pt_n;
				ovr_q    <= ovr_n;
			end
		end
	end

endmodule

// File: hdl/rtp_pkt_outq.sv
// Result queue: takes up to two results a cycle and hands them out one per transfer.
module rtp_pkt_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_count,
	input  rtp_pkt_pkg::res_t push0,
	input  rtp_pkt_pkg::res_t push1,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output rtp_pkt_pkg::res_t out_res
);
	import rtp_pkt_pkg::*;

	res_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q, wr_next;
	logic [QUEUE_AW:0]   cnt_q;
	logic                pop;

	assign wr_next   = wr_q + QUEUE_AW'(1);
	assign out_valid = (cnt_q != '0);
	assign out_res   = entry_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign space     = (cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QUEUE_AW'(push_count);
			cnt_q <= cnt_q + (QUEUE_AW + 1)'(push_count) - (QUEUE_AW + 1)'(pop);
			if (pop) begin
				rd_q <= rd_q + QUEUE_AW'(1);
			end
		end
	end

endmodule

// File: hdl/rtp_packet_parser.sv
// Top level of the RTP packet parser: byte input stream, result output stream.
//
//   channel   dir  tdata                       tuser   tlast
//   s_axis    in   data_byte                   -       last_byte
//   m_axis    out  header, csrc, ext, payload  kind    packet_done
//
// One byte is taken per cycle while the result queue has room; its results are registered there and leave in order.
// The last byte of a packet adds the end status after any result of its own.
// A four-entry result queue lets input continue while the output is stalled;
// input stalls when fewer than two entries are free.
// Reset clears the packet state and empties the queue.
module rtp_packet_parser #(
	parameter int POSITION_BITS = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] version, [4:2] flags, [11:5] ptype, [27:12] seq_num,
	// [59:28] timestamp, [91:60] source_id, [99:92] element_id,
	// [131:100] data_value, [139:132] pad_bytes, [141:140] status, rest zero
	output logic [143:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,  // [2:0] kind
	output logic         m_axis_tlast
);
	import rtp_pkt_pkg::*;

	logic       take;
	logic [1:0] res_count;
	res_t       res0, res1, out_res;

	assign take = s_axis_tvalid && s_axis_tready;

	rtp_pkt_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	rtp_pkt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (take ? res_count : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.space      (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.status, out_res.pad_bytes, out_res.data_value,
		out_res.element_id, out_res.source_id, out_res.timestamp,
		out_res.seq_num, out_res.ptype, out_res.flags, out_res.version};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.packet_done;

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with an empty result queue");

	a_done_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 3'(KIND_END))
		else $error("packet end flagged on a result that is not an end status");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && s_axis_tlast |=> m_axis_tvalid)
		else $error("no result pending after the last byte of a packet");

endmodule

// File: dv/rtp_result_checker.sv
// Checker for the RTP packet parser: predicts the results of each byte transfer and compares them.
module rtp_result_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [143:0] m_axis_tdata,
	input  logic [2:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           outstanding,
	output int           results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtp_pkt_pkg::*;

	typedef enum logic [3:0] {
		PH_FIXED,
		PH_CSRC,
		PH_EXTHDR,
		PH_ONE_HDR,
		PH_TWO_ID,
		PH_TWO_LEN,
		PH_ELEM_DATA,
		PH_SKIP,
		PH_OPAQUE,
		PH_PAYLOAD
	} parse_phase_t;

	localparam logic [17:0] POS_MAX = '1;

	parse_phase_t phase;
	logic [17:0]  byte_pos;
	logic [17:0]  ext_end;
	logic [17:0]  payload_cnt;
	logic [3:0]   csrc_cnt;
	logic [2:0]   hdr_flags;
	logic [31:0]  word_acc;
	logic [15:0]  seq_reg;
	logic [31:0]  ts_reg;
	logic [31:0]  ssrc_reg;
	logic [15:0]  profile_reg;
	logic [7:0]   elem_id;
	logic [8:0]   elem_left;
	logic [1:0]   ver_reg;
	logic [6:0]   pt_reg;
	logic         overrun;

	res_t expected_records[$];
	int   errors = 0;
	int   checked = 0;

	assign fail_count      = errors;
	assign results_checked = checked;

	task automatic clear_packet();
		phase       = PH_FIXED;
		byte_pos    = '0;
		ext_end     = '0;
		payload_cnt = '0;
		csrc_cnt    = '0;
		hdr_flags   = '0;
		word_acc    = '0;
		seq_reg     = '0;
		ts_reg      = '0;
		ssrc_reg    = '0;
		profile_reg = '0;
		elem_id     = '0;
		elem_left   = '0;
		ver_reg     = '0;
		pt_reg      = '0;
		overrun     = 1'b0;
	endtask

	task automatic expect_result(input res_t r);
		expected_records.insert(expected_records.size(), r);
	endtask

	function automatic res_t blank_record(input kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic res_t header_record(input logic [15:0] profile);
		res_t r;
		r = blank_record(KIND_HEADER);
		r.version    = ver_reg;
		r.flags      = hdr_flags;
		r.ptype      = pt_reg;
		r.seq_num    = seq_reg;
		r.timestamp  = ts_reg;
		r.source_id  = ssrc_reg;
		r.data_value = {16'h0000, profile};
		return r;
	endfunction

	function automatic parse_phase_t element_header_phase();
		return (profile_reg == PROFILE_ONE) ? PH_ONE_HDR : PH_TWO_ID;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [17:0] pos;
		logic [17:0] npos;
		logic [17:0] rel;
		logic [31:0] ext_sum;
		logic        hdr_check;
		res_t        r;
		logic [1:0]  st;
		logic [7:0]  pad;
		pos       = byte_pos;
		npos      = (pos < POS_MAX) ? pos + 18'd1 : pos;
		hdr_check = 1'b0;
		word_acc  = {word_acc[23:0], b};
		case (phase)
		PH_FIXED: begin
			if (pos == 0) begin
				ver_reg      = b[7:6];
				hdr_flags[2] = b[5];
				hdr_flags[1] = b[4];
				csrc_cnt     = b[3:0];
			end else if (pos == 1) begin
				hdr_flags[0] = b[7];
				pt_reg       = b[6:0];
			end else if (pos == 3) begin
				seq_reg = word_acc[15:0];
			end else if (pos == 7) begin
				ts_reg = word_acc;
			end else if (pos >= 11) begin
				ssrc_reg = word_acc;
				if (!hdr_flags[1]) begin
					expect_result(header_record(16'h0000));
					phase = (csrc_cnt != 0) ? PH_CSRC : PH_PAYLOAD;
				end else begin
					phase = (csrc_cnt != 0) ? PH_CSRC : PH_EXTHDR;
				end
			end
		end
		PH_CSRC: begin
			rel = pos - 18'd12;
			if (rel[1:0] == 2'd3) begin
				r = blank_record(KIND_CSRC);
				r.data_value = word_acc;
				expect_result(r);
				if (((rel >> 2) + 18'd1) >= 18'(csrc_cnt))
					phase = hdr_flags[1] ? PH_EXTHDR : PH_PAYLOAD;
			end
		end
		PH_EXTHDR: begin
			rel = pos - (18'd12 + 18'(csrc_cnt) * 18'd4);
			if (rel == 1) begin
				profile_reg = word_acc[15:0];
				expect_result(header_record(profile_reg));
			end else if (rel >= 3) begin
				ext_sum = 32'(npos) + 32'(word_acc[15:0]) * 32'd4;
				ext_end = (ext_sum > 32'(POS_MAX)) ? POS_MAX : ext_sum[17:0];
				if (profile_reg == PROFILE_ONE || profile_reg == PROFILE_TWO)
					phase = element_header_phase();
				else
					phase = PH_OPAQUE;
				hdr_check = 1'b1;
			end
		end
		PH_ONE_HDR: begin
			if (b != 0) begin
				elem_id   = {4'h0, b[7:4]};
				elem_left = 9'(b[3:0]) + 9'd1;
				phase     = (b[7:4] == ID_RESERVED) ? PH_SKIP : PH_ELEM_DATA;
			end
			hdr_check = (phase != PH_ELEM_DATA);
		end
		PH_TWO_ID: begin
			if (b != 0) begin
				elem_id = b;
				phase   = PH_TWO_LEN;
			end else begin
				hdr_check = 1'b1;
			end
		end
		PH_TWO_LEN: begin
			if (pos >= ext_end)
				overrun = 1'b1;
			elem_left = 9'(b);
			if (b == 0) begin
				phase     = PH_TWO_ID;
				hdr_check = 1'b1;
			end else begin
				phase = PH_ELEM_DATA;
			end
		end
		PH_ELEM_DATA: begin
			if (pos >= ext_end)
				overrun = 1'b1;
			r = blank_record(KIND_EXT);
			r.element_id = elem_id;
			r.data_value = 32'(b);
			expect_result(r);
			elem_left = elem_left - 9'd1;
			if (elem_left == 0) begin
				phase     = element_header_phase();
				hdr_check = 1'b1;
			end
		end
		PH_SKIP: begin
			hdr_check = 1'b1;
		end
		PH_OPAQUE: begin
			r = blank_record(KIND_EXT);
			r.data_value = 32'(b);
			expect_result(r);
			hdr_check = 1'b1;
		end
		default: begin
			phase = PH_PAYLOAD;
			r = blank_record(KIND_PAYLOAD);
			r.data_value = 32'(b);
			expect_result(r);
			if (payload_cnt < POS_MAX)
				payload_cnt = payload_cnt + 18'd1;
		end
		endcase
		if (hdr_check && npos >= ext_end)
			phase = PH_PAYLOAD;
		byte_pos = npos;
		if (last) begin
			st  = ST_OK;
			pad = '0;
			if (phase != PH_PAYLOAD) begin
				st = ST_TRUNCATED;
			end else if (overrun) begin
				st = ST_OVERRUN;
			end else if (hdr_flags[2]) begin
				if (payload_cnt == 0 || 18'(b) > payload_cnt)
					st = ST_BAD_PAD;
				else
					pad = b;
			end
			r = blank_record(KIND_END);
			r.pad_bytes   = pad;
			r.status      = st;
			r.packet_done = 1'b1;
			expect_result(r);
			clear_packet();
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (expected_records.size() == 0) begin
			$error("result of kind %0d arrived with nothing expected", m_axis_tuser);
			errors++;
		end else begin
			want = expected_records.pop_front();
			checked++;
			check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
			check_field("version", 32'(want.version), 32'(m_axis_tdata[1:0]));
			check_field("flags", 32'(want.flags), 32'(m_axis_tdata[4:2]));
			check_field("ptype", 32'(want.ptype), 32'(m_axis_tdata[11:5]));
			check_field("seq_num", 32'(want.seq_num), 32'(m_axis_tdata[27:12]));
			check_field("timestamp", want.timestamp, m_axis_tdata[59:28]);
			check_field("source_id", want.source_id, m_axis_tdata[91:60]);
			check_field("element_id", 32'(want.element_id), 32'(m_axis_tdata[99:92]));
			check_field("data_value", want.data_value, m_axis_tdata[131:100]);
			check_field("pad_bytes", 32'(want.pad_bytes), 32'(m_axis_tdata[139:132]));
			check_field("status", 32'(want.status), 32'(m_axis_tdata[141:140]));
			check_field("packet_done", 32'(want.packet_done), 32'(m_axis_tlast));
			check_field("tdata_spare", 32'h0, 32'(m_axis_tdata[143:142]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet();
			expected_records.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			outstanding <= expected_records.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Top of the RTP packet parser testbench: clock, reset, packet stimulus, output stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rtp_pkt_pkg::*;

	localparam int TARGET_BYTES = 1300;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_RARE_STALL,
		RX_MASK
	} rx_mode_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;

	int fail_count;
	int outstanding;
	int results_checked;

	logic [7:0] pkt[$];
	int         burst_left = 0;
	int         bytes_sent = 0;
	int         packets_sent = 0;
	int         quiet_cycles = 0;
	logic       hold_wanted = 1'b0;
	logic       hold_served = 1'b0;

	rtp_packet_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	rtp_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic pkt_add(input logic [7:0] v);
		pkt.insert(pkt.size(), v);
	endtask

	task automatic send_packet();
		int gap;
		foreach (pkt[i]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= pkt[i];
			s_axis_tlast  <= (i == pkt.size() - 1);
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			burst_left--;
			bytes_sent++;
		end
		packets_sent++;
	endtask

	task automatic build_random_packet();
		logic [1:0]  ver;
		logic        pad_on;
		logic        ext_on;
		logic [3:0]  cc;
		logic [3:0]  id;
		logic [15:0] profile;
		logic [15:0] ext_words;
		logic [7:0]  body[$];
		int          sel;
		int          len;
		int          pay_len;
		int          cut;
		pkt.delete();
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 20)) pkt_add(8'($urandom));
			return;
		end
		ver    = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd2;
		pad_on = 1'($urandom);
		ext_on = ($urandom_range(0, 9) < 7);
		if ($urandom_range(0, 9) < 7)
			cc = 4'd0;
		else if ($urandom_range(0, 9) == 0)
			cc = 4'd15;
		else
			cc = 4'($urandom_range(1, 3));
		pkt_add({ver, pad_on, ext_on, cc});
		pkt_add(8'($urandom));
		repeat (10 + 4 * cc) pkt_add(8'($urandom));
		if (ext_on) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				profile = PROFILE_ONE;
			else if (sel < 75)
				profile = PROFILE_TWO;
			else
				profile = 16'($urandom);
			repeat ($urandom_range(0, 4)) begin
				sel = $urandom_range(0, 99);
				if (profile == PROFILE_ONE) begin
					if (sel < 15) begin
						body.insert(body.size(), 8'h00);
					end else begin
						id  = (sel < 25) ? ID_RESERVED : 4'($urandom_range(0, 14));
						len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
							: $urandom_range(0, 3);
						body.insert(body.size(), {id, 4'(len)});
						repeat (len + 1) body.insert(body.size(), 8'($urandom));
					end
				end else if (profile == PROFILE_TWO) begin
					if (sel < 12) begin
						body.insert(body.size(), 8'h00);
					end else begin
						if (sel < 26)
							len = 0;
						else if (sel < 28)
							len = $urandom_range(16, 255);
						else
							len = $urandom_range(1, 6);
						body.insert(body.size(), 8'($urandom_range(1, 255)));
						body.insert(body.size(), 8'(len));
						repeat (len) body.insert(body.size(), 8'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 8)) body.insert(body.size(), 8'($urandom));
				end
			end
			while (body.size() % 4 != 0) body.insert(body.size(), 8'h00);
			ext_words = 16'(body.size() / 4);
			sel = $urandom_range(0, 99);
			if (sel < 10 && ext_words != 0)
				ext_words = ext_words - 16'($urandom_range(1, ext_words));
			else if (sel < 14)
				ext_words = ext_words + 16'($urandom_range(1, 3));
			else if (sel < 16)
				ext_words = 16'hFFFF;
			pkt_add(profile[15:8]);
			pkt_add(profile[7:0]);
			pkt_add(ext_words[15:8]);
			pkt_add(ext_words[7:0]);
			foreach (body[i]) pkt_add(body[i]);
		end
		pay_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
		repeat (pay_len) pkt_add(8'($urandom));
		if (pad_on && pay_len != 0) begin
			if ($urandom_range(0, 4) != 0)
				pkt[pkt.size() - 1] = 8'($urandom_range(0, pay_len));
			else
				pkt[pkt.size() - 1] = 8'($urandom);
		end
		if (pkt.size() > 1 && $urandom_range(0, 99) < 12) begin
			cut = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > cut) void'(pkt.pop_back());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pkt.delete();
		pkt_add(8'hE0);
		repeat (11) pkt_add(8'hFF);
		send_packet();
		pkt.delete();
		pkt_add(8'h00);
		send_packet();
		pkt.delete();
		repeat (13) pkt_add(8'h00);
		send_packet();

		while (bytes_sent < TARGET_BYTES) begin
			build_random_packet();
			if (packets_sent == 8)
				hold_wanted = 1'b1;
			send_packet();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (outstanding != 0)
			$error("%0d results never arrived", outstanding);
		$display("summary: %0d packets and %0d bytes sent, %0d results checked,",
			packets_sent, bytes_sent, results_checked);
		$display("summary: including a %0d-cycle output hold with the input backed up",
			HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		rx_mode_t   mode;
		logic [7:0] mask;
		int         span;
		int         tick;
		tick = 0;
		m_axis_tready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			mask = 8'($urandom) | 8'h01;
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(posedge clk);
				if (hold_wanted && !hold_served) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_served = 1'b1;
				end
				tick++;
				case (mode)
				RX_ALWAYS:     m_axis_tready <= 1'b1;
				RX_COIN:       m_axis_tready <= 1'($urandom);
				RX_RARE_STALL: m_axis_tready <= ($urandom_range(0, 5) != 0);
				default:       m_axis_tready <= mask[3'(tick)];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transfer for %0d cycles", QUIET_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

endmodule

// File: sim.f
hdl/rtp_pkt_pkg.sv
hdl/rtp_pkt_core.sv
hdl/rtp_pkt_outq.sv
hdl/rtp_packet_parser.sv
dv/rtp_result_checker.sv
dv/testbench.sv
